### rtl/dns_query_retry_tracker_assert.svh
// Assertion macros used by the checker file dqrt_checker.sv.
`ifndef DNS_QUERY_RETRY_TRACKER_ASSERT_SVH
`define DNS_QUERY_RETRY_TRACKER_ASSERT_SVH

// same-cycle implication
`define DQRT_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define DQRT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

### rtl/dqrt_pkg.sv
package dqrt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_SERVERS_DEF = 8;
  localparam int MAX_MSG_LEN_DEF = 512;
  localparam int HDR_BYTES       = 12;

  localparam logic [15:0] INIT_TO_RST   = 16'd1000;
  localparam logic [15:0] MAX_TO_RST    = 16'd8000;
  localparam logic [3:0]  RETRY_LIM_RST = 4'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_INIT_TO   = 3'd0;
  localparam logic [2:0] CFG_MAX_TO    = 3'd1;
  localparam logic [2:0] CFG_RETRY_LIM = 3'd2;
  localparam logic [2:0] CFG_ROTATE    = 3'd3;
  localparam logic [2:0] CFG_SRV_CNT   = 3'd4;

  typedef enum logic [1:0] {
    OP_ISSUE  = 2'd0,
    OP_RESP   = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_SEND       = 2'd0,
    EV_DONE       = 2'd1,
    EV_REFUSED    = 2'd2,
    EV_CANCEL_ACK = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_TIMEOUT    = 4'd1,
    ST_TRUNCATED  = 4'd2,
    ST_CANCELLED  = 4'd3,
    ST_INVALID    = 4'd4,
    ST_FORMERR    = 4'd5,
    ST_SERVFAIL   = 4'd6,
    ST_NXDOMAIN   = 4'd7,
    ST_REFUSED    = 4'd8,
    ST_NO_SERVERS = 4'd9,
    ST_TABLE_FULL = 4'd10,
    ST_BAD_LEN    = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_EV,
    S_CANCEL_RD,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    WK_CANCEL,
    WK_TIMER,
    WK_RESP
  } walk_t;

  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  server;
    logic [3:0]  retries;
    logic [15:0] timeout;
    logic [15:0] remaining;
  } entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [15:0] id;
    logic [2:0]  server;
    status_t     status;
    logic [3:0]  retries;
  } result_t;

  // v mod c for small v (at most 15), c at least 2
  function automatic logic [3:0] mod_small(logic [3:0] v, logic [3:0] c);
    logic [3:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      if (c != 4'd0 && r >= c) r = r - c;
    end
    return r;
  endfunction

  function automatic status_t map_rcode(logic [3:0] rc);
    status_t s;
    case (rc)
      4'd0:    s = ST_OK;
      4'd1:    s = ST_FORMERR;
      4'd2:    s = ST_SERVFAIL;
      4'd3:    s = ST_NXDOMAIN;
      4'd5:    s = ST_REFUSED;
      default: s = ST_INVALID;
    endcase
    return s;
  endfunction

endpackage

### rtl/dqrt_ram.sv
module dqrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/dns_query_retry_tracker.sv
// Tracks up to TABLE_DEPTH outstanding DNS queries. Pulse start with an
// operation while busy is low; busy drops in the same cycle that shows the
// final result word of that operation, if it has any. Each result word is
// valid for exactly one cycle on strobe and cannot be held off; last marks the
// final word of an operation. A tick, or a response with a good length and qr
// set, walks the live entries oldest first, each entry visited through a read
// state and an event state because the entry memory has a registered read.
// Configuration is to be written only while busy is low; the block itself
// does not enforce this.
module dns_query_retry_tracker #(
  parameter int TABLE_DEPTH = dqrt_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_SERVERS = dqrt_pkg::MAX_SERVERS_DEF,
  parameter int MAX_MSG_LEN = dqrt_pkg::MAX_MSG_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] msg_id,
  input  logic [15:0] msg_len,
  input  logic        resp_qr,
  input  logic        resp_tc,
  input  logic [3:0]  resp_rcode,
  input  logic [3:0]  cancel_slot,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [1:0]  event_kind,
  output logic [3:0]  slot,
  output logic [15:0] query_id,
  output logic [2:0]  server_index,
  output logic [3:0]  status,
  output logic [3:0]  retries_done,
  output logic        last
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = $bits(dqrt_pkg::entry_t);

  // configuration
  logic [15:0] init_to, max_to;
  logic [3:0]  retry_lim, srv_cnt;
  logic        rotate;
  logic [2:0]  next_server;

  // control state
  dqrt_pkg::state_t  state, state_next;
  dqrt_pkg::walk_t   mode, mode_next;
  logic [CNT_W-1:0]  j, j_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [TABLE_DEPTH-1:0] valid, canc;
  logic [IDX_W-1:0]  ord [TABLE_DEPTH];
  logic [CNT_W-1:0]  ord_cnt;
  logic [15:0]       q_id;
  dqrt_pkg::status_t q_status;

  logic              pend_valid;
  dqrt_pkg::result_t pend, out_res, res;
  logic              emit, do_issue, do_free, do_mark, ns_adv;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  dqrt_pkg::entry_t  ram_wdata, rdata;
  logic [ENT_W-1:0]  rdata_raw;

  logic [3:0]        cnt_eff;
  logic              bad_len, cx_ok;
  logic [IDX_W-1:0]  free_idx, cx_idx;
  logic              free_found;
  logic [16:0]       dbl;
  logic [15:0]       t_clamp, rem;

  dqrt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );
  assign rdata = dqrt_pkg::entry_t'(rdata_raw);

  assign cnt_eff = (32'(srv_cnt) > MAX_SERVERS) ? 4'(MAX_SERVERS) : srv_cnt;
  assign bad_len = (32'(msg_len) < dqrt_pkg::HDR_BYTES) || (32'(msg_len) > MAX_MSG_LEN);
  assign cx_idx  = IDX_W'(cancel_slot);
  assign cx_ok   = (32'(cancel_slot) < TABLE_DEPTH) && valid[cx_idx];
  assign busy    = (state != dqrt_pkg::S_IDLE);

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // timer arithmetic on the entry read back
  assign rem     = (rdata.remaining != 16'd0) ? rdata.remaining - 16'd1 : 16'd0;
  assign dbl     = {rdata.timeout, 1'b0};
  assign t_clamp = (dbl > {1'b0, max_to}) ? max_to : dbl[15:0];

  always_comb begin
    state_next = state;
    mode_next  = mode;
    j_next     = j;
    cur_next   = cur;
    emit       = 1'b0;
    res        = '0;
    do_issue   = 1'b0;
    do_free    = 1'b0;
    do_mark    = 1'b0;
    ns_adv     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur;
    ram_wdata  = rdata;
    ram_raddr  = ord[j[IDX_W-1:0]];
    unique case (state)
      dqrt_pkg::S_IDLE: begin
        if (start) begin
          unique case (dqrt_pkg::op_t'(operation))
            dqrt_pkg::OP_ISSUE: begin
              state_next  = dqrt_pkg::S_FIN;
              emit        = 1'b1;
              res.kind    = dqrt_pkg::EV_REFUSED;
              res.id      = msg_id;
              if (bad_len) res.status = dqrt_pkg::ST_BAD_LEN;
              else if (cnt_eff == 4'd0) res.status = dqrt_pkg::ST_NO_SERVERS;
              else if (!free_found) res.status = dqrt_pkg::ST_TABLE_FULL;
              else begin
                res.kind   = dqrt_pkg::EV_SEND;
                res.slot   = 4'(free_idx);
                res.server = next_server;
                res.status = dqrt_pkg::ST_OK;
                do_issue   = 1'b1;
                ns_adv     = rotate && (cnt_eff > 4'd1);
                ram_we     = 1'b1;
                ram_waddr  = free_idx;
                ram_wdata  = '{id: msg_id, server: next_server, retries: 4'd0,
                               timeout: init_to, remaining: init_to};
              end
            end
            dqrt_pkg::OP_RESP: begin
              j_next    = '0;
              mode_next = dqrt_pkg::WK_RESP;
              state_next = (!bad_len && resp_qr) ? dqrt_pkg::S_WALK_RD : dqrt_pkg::S_FIN;
            end
            dqrt_pkg::OP_TICK: begin
              j_next     = '0;
              mode_next  = dqrt_pkg::WK_CANCEL;
              state_next = dqrt_pkg::S_WALK_RD;
            end
            dqrt_pkg::OP_CANCEL: begin
              if (cx_ok) begin
                ram_raddr  = cx_idx;
                cur_next   = cx_idx;
                do_mark    = 1'b1;
                state_next = dqrt_pkg::S_CANCEL_RD;
              end else begin
                emit       = 1'b1;
                res.kind   = dqrt_pkg::EV_REFUSED;
                res.slot   = cancel_slot;
                res.status = dqrt_pkg::ST_INVALID;
                state_next = dqrt_pkg::S_FIN;
              end
            end
            default: ;
          endcase
        end
      end
      dqrt_pkg::S_WALK_RD: begin
        if (j >= ord_cnt) begin
          if (mode == dqrt_pkg::WK_CANCEL) begin
            mode_next = dqrt_pkg::WK_TIMER;
            j_next    = '0;
          end else begin
            state_next = dqrt_pkg::S_FIN;
          end
        end else begin
          cur_next   = ord[j[IDX_W-1:0]];
          state_next = dqrt_pkg::S_WALK_EV;
        end
      end
      dqrt_pkg::S_WALK_EV: begin
        state_next  = dqrt_pkg::S_WALK_RD;
        j_next      = j + CNT_W'(1);
        res.slot    = 4'(cur);
        res.id      = rdata.id;
        res.server  = rdata.server;
        res.retries = rdata.retries;
        res.kind    = dqrt_pkg::EV_DONE;
        unique case (mode)
          dqrt_pkg::WK_CANCEL: begin
            if (canc[cur]) begin
              emit       = 1'b1;
              res.status = dqrt_pkg::ST_CANCELLED;
              do_free    = 1'b1;
              j_next     = j;
            end
          end
          dqrt_pkg::WK_RESP: begin
            if (!canc[cur] && rdata.id == q_id) begin
              emit       = 1'b1;
              res.status = q_status;
              do_free    = 1'b1;
              state_next = dqrt_pkg::S_FIN;
            end
          end
          dqrt_pkg::WK_TIMER: begin
            ram_we = 1'b1;
            if (rem != 16'd0) begin
              ram_wdata.remaining = rem;
            end else if (rdata.retries < retry_lim) begin
              ram_wdata.retries   = rdata.retries + 4'd1;
              ram_wdata.timeout   = t_clamp;
              ram_wdata.remaining = t_clamp;
              if (rotate && cnt_eff > 4'd1)
                ram_wdata.server = 3'(dqrt_pkg::mod_small({1'b0, rdata.server} + 4'd1,
                                                          cnt_eff));
              emit        = 1'b1;
              res.server  = ram_wdata.server;
              res.retries = ram_wdata.retries;
              if (cnt_eff == 4'd0) begin
                res.status = dqrt_pkg::ST_NO_SERVERS;
                do_free    = 1'b1;
                j_next     = j;
              end else begin
                res.kind   = dqrt_pkg::EV_SEND;
                res.status = dqrt_pkg::ST_OK;
              end
            end else begin
              emit       = 1'b1;
              res.status = dqrt_pkg::ST_TIMEOUT;
              do_free    = 1'b1;
              j_next     = j;
            end
          end
          default: ;
        endcase
      end
      dqrt_pkg::S_CANCEL_RD: begin
        emit        = 1'b1;
        res.kind    = dqrt_pkg::EV_CANCEL_ACK;
        res.slot    = 4'(cur);
        res.id      = rdata.id;
        res.server  = rdata.server;
        res.status  = dqrt_pkg::ST_OK;
        res.retries = rdata.retries;
        state_next  = dqrt_pkg::S_FIN;
      end
      dqrt_pkg::S_FIN: state_next = dqrt_pkg::S_IDLE;
      default: state_next = dqrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_to     <= dqrt_pkg::INIT_TO_RST;
      max_to      <= dqrt_pkg::MAX_TO_RST;
      retry_lim   <= dqrt_pkg::RETRY_LIM_RST;
      rotate      <= 1'b1;
      srv_cnt     <= 4'd0;
      next_server <= 3'd0;
      valid       <= '0;
      canc        <= '0;
      ord_cnt     <= '0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
      last        <= 1'b0;
      mode        <= dqrt_pkg::WK_CANCEL;
      j           <= '0;
    end else begin
      mode <= mode_next;
      j    <= j_next;
      if (ns_adv)
        next_server <= 3'(dqrt_pkg::mod_small({1'b0, next_server} + 4'd1, cnt_eff));
      if (cfg_we) begin
        case (cfg_addr)
          dqrt_pkg::CFG_INIT_TO:   if (cfg_data != 16'd0) init_to <= cfg_data;
          dqrt_pkg::CFG_MAX_TO:    if (cfg_data != 16'd0) max_to <= cfg_data;
          dqrt_pkg::CFG_RETRY_LIM: retry_lim <= cfg_data[3:0];
          dqrt_pkg::CFG_ROTATE:    rotate <= cfg_data[0];
          dqrt_pkg::CFG_SRV_CNT: begin
            srv_cnt     <= cfg_data[3:0];
            next_server <= 3'd0;
          end
          default: ;
        endcase
      end
      if (do_issue) begin
        valid[free_idx] <= 1'b1;
        canc[free_idx]  <= 1'b0;
        ord_cnt         <= ord_cnt + CNT_W'(1);
      end
      if (do_mark) canc[cx_idx] <= 1'b1;
      if (do_free) begin
        valid[cur] <= 1'b0;
        canc[cur]  <= 1'b0;
        ord_cnt    <= ord_cnt - CNT_W'(1);
      end
      // one word is held back so the final one can carry last
      strobe <= 1'b0;
      last   <= 1'b0;
      if (emit) begin
        pend       <= res;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_res <= pend;
          strobe  <= 1'b1;
        end
      end else if (state == dqrt_pkg::S_FIN && pend_valid) begin
        out_res    <= pend;
        strobe     <= 1'b1;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

  // age list and latched operands
  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (state == dqrt_pkg::S_IDLE && start) begin
      q_id     <= msg_id;
      q_status <= resp_tc ? dqrt_pkg::ST_TRUNCATED : dqrt_pkg::map_rcode(resp_rcode);
    end
    if (do_issue) ord[ord_cnt[IDX_W-1:0]] <= free_idx;
    if (do_free) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (CNT_W'(i) >= j) ord[i] <= ord[i+1];
      end
    end
  end

  assign event_kind   = out_res.kind;
  assign slot         = out_res.slot;
  assign query_id     = out_res.id;
  assign server_index = out_res.server;
  assign status       = out_res.status;
  assign retries_done = out_res.retries;

endmodule

### rtl/dqrt_checker.sv
`include "dns_query_retry_tracker_assert.svh"

module dqrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic       last,
  input logic [1:0] event_kind,
  input logic [3:0] status
);

  `DQRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `DQRT_ASSERT_NOW(a_mid_busy, strobe && !last, busy, "non-final word while idle")
  `DQRT_ASSERT_NOW(a_last_idle, strobe && last, !busy, "final word while still busy")
  `DQRT_ASSERT_NOW(a_send_ok, strobe && event_kind == dqrt_pkg::EV_SEND, status == dqrt_pkg::ST_OK, "send word not ok")

endmodule

bind dns_query_retry_tracker dqrt_checker u_dqrt_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .last       (last),
  .event_kind (event_kind),
  .status     (status)
);

### bench/dns_query_retry_tracker_tb.sv
`timescale 1ns / 1ps

module dns_query_retry_tracker_tb;
  import dqrt_pkg::*;

  localparam int DEPTH = 16;
  localparam int NSRV = 8;
  localparam int MAXLEN = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = 2'd0;
  logic [15:0] msg_id = 16'd0;
  logic [15:0] msg_len = 16'd0;
  logic        resp_qr = 1'b0;
  logic        resp_tc = 1'b0;
  logic [3:0]  resp_rcode = 4'd0;
  logic [3:0]  cancel_slot = 4'd0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        strobe;
  logic [1:0]  event_kind;
  logic [3:0]  slot;
  logic [15:0] query_id;
  logic [2:0]  server_index;
  logic [3:0]  status;
  logic [3:0]  retries_done;
  logic        last;

  dns_query_retry_tracker uut (.*);

  class query_table_sb;
    bit          live[DEPTH];
    bit          cxl[DEPTH];
    logic [15:0] qid[DEPTH];
    logic [2:0]  srv[DEPTH];
    logic [3:0]  tries[DEPTH];
    int unsigned tmo[DEPTH];
    int unsigned left[DEPTH];
    int unsigned rank[DEPTH];
    logic [2:0]  rr_ptr;
    int unsigned init_to, max_to, rlim, rot, scnt;
    result_t     due_words[$];
    bit          due_last[$];
    int          errors;

    function void clear();
      foreach (live[i]) begin
        live[i] = 0;
        cxl[i] = 0;
      end
      rr_ptr = 0;
      init_to = INIT_TO_RST;
      max_to = MAX_TO_RST;
      rlim = RETRY_LIM_RST;
      rot = 1;
      scnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_INIT_TO:   if (val != 0) init_to = val;
        CFG_MAX_TO:    if (val != 0) max_to = val;
        CFG_RETRY_LIM: rlim = val[3:0];
        CFG_ROTATE:    rot = val[0];
        CFG_SRV_CNT: begin
          scnt = val[3:0];
          rr_ptr = 0;
        end
        default: ;
      endcase
    endfunction

    function void push(kind_t k, int s, logic [15:0] id, logic [2:0] sv, status_t st,
                       logic [3:0] rt);
      result_t w;
      w = '{kind: k, slot: s[3:0], id: id, server: sv, status: st, retries: rt};
      due_words.push_back(w);
      due_last.push_back(1'b0);
    endfunction

    function void retire(int s, status_t st);
      push(EV_DONE, s, qid[s], srv[s], st, tries[s]);
      live[s] = 0;
      cxl[s] = 0;
      foreach (live[i])
        if (live[i] && rank[i] > rank[s]) rank[i]--;
    endfunction

    function void oldest_first(ref int q[$]);
      q.delete();
      for (int r = 0; r < DEPTH; r++)
        for (int i = 0; i < DEPTH; i++)
          if (live[i] && rank[i] == r) q.push_back(i);
    endfunction

    function logic [15:0] live_id();
      int q[$];
      oldest_first(q);
      if (q.size() == 0) return 16'($urandom);
      return qid[q[$urandom_range(q.size() - 1)]];
    endfunction

    function void note_item(logic [1:0] op, logic [15:0] id, logic [15:0] len, logic qr,
                            logic tc, logic [3:0] rc, logic [3:0] cs);
      int unsigned cnt, t, n0;
      int q[$];
      int s;
      bit len_ok;
      cnt = (scnt > NSRV) ? NSRV : scnt;
      n0 = due_words.size();
      len_ok = (len >= HDR_BYTES) && (len <= MAXLEN);
      case (op)
        OP_ISSUE: begin
          s = -1;
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!live[i]) s = i;
          if (!len_ok) push(EV_REFUSED, 0, id, 0, ST_BAD_LEN, 0);
          else if (cnt == 0) push(EV_REFUSED, 0, id, 0, ST_NO_SERVERS, 0);
          else if (s < 0) push(EV_REFUSED, 0, id, 0, ST_TABLE_FULL, 0);
          else begin
            oldest_first(q);
            rank[s] = q.size();
            live[s] = 1;
            cxl[s] = 0;
            qid[s] = id;
            srv[s] = rr_ptr;
            tries[s] = 0;
            tmo[s] = init_to;
            left[s] = init_to;
            push(EV_SEND, s, id, rr_ptr, ST_OK, 0);
            if (rot && cnt > 1) rr_ptr = 3'((rr_ptr + 1) % cnt);
          end
        end
        OP_RESP: begin
          if (len_ok && qr) begin
            oldest_first(q);
            foreach (q[j])
              if (!cxl[q[j]] && qid[q[j]] == id) begin
                retire(q[j], tc ? ST_TRUNCATED : map_rcode(rc));
                break;
              end
          end
        end
        OP_CANCEL: begin
          if (live[cs]) begin
            cxl[cs] = 1;
            push(EV_CANCEL_ACK, cs, qid[cs], srv[cs], ST_OK, tries[cs]);
          end else push(EV_REFUSED, cs, 0, 0, ST_INVALID, 0);
        end
        default: begin
          oldest_first(q);
          foreach (q[j])
            if (cxl[q[j]]) retire(q[j], ST_CANCELLED);
          oldest_first(q);
          foreach (q[j]) begin
            s = q[j];
            if (left[s] > 0) left[s]--;
            if (left[s] != 0) continue;
            if (tries[s] < rlim) begin
              t = tmo[s] * 2;
              tries[s]++;
              if (t > max_to) t = max_to;
              tmo[s] = t;
              left[s] = t;
              if (rot && cnt > 1) srv[s] = 3'((srv[s] + 1) % cnt);
              if (cnt == 0) retire(s, ST_NO_SERVERS);
              else push(EV_SEND, s, qid[s], srv[s], ST_OK, tries[s]);
            end else retire(s, ST_TIMEOUT);
          end
        end
      endcase
      if (due_words.size() > n0) due_last[due_last.size() - 1] = 1'b1;
    endfunction

    function void check_word(logic [1:0] k, logic [3:0] sl, logic [15:0] id, logic [2:0] sv,
                             logic [3:0] st, logic [3:0] rt, logic lst);
      result_t e;
      logic [15:0] want[7], got[7];
      string fname[7];
      bit el;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d slot=%0d id=%0h", $time, k, sl, id);
        errors++;
        return;
      end
      e = due_words.pop_front();
      el = due_last.pop_front();
      fname = '{"event_kind", "slot", "query_id", "server_index", "status", "retries_done",
                "last"};
      want = '{e.kind, e.slot, e.id, e.server, e.status, e.retries, el};
      got = '{k, sl, id, sv, st, rt, lst};
      for (int f = 0; f < 7; f++)
        if (want[f] !== got[f]) begin
          $display("%0t: %s expected %0h actual %0h", $time, fname[f], want[f], got[f]);
          errors++;
        end
    endfunction
  endclass

  query_table_sb sb = new();
  int idle_pct = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && strobe)
      sb.check_word(event_kind, slot, query_id, server_index, status, retries_done, last);

  task automatic send_item(logic [1:0] op, logic [15:0] id, logic [15:0] len, logic qr,
                           logic tc, logic [3:0] rc, logic [3:0] cs);
    operation <= op;
    msg_id <= id;
    msg_len <= len;
    resp_qr <= qr;
    resp_tc <= tc;
    resp_rcode <= rc;
    cancel_slot <= cs;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(op, id, len, qr, tc, rc, cs);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // items with no result may still be walking the table, so also wait for busy to fall, then pad
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int it, int mt, int rl, int ro, int sc);
    write_reg(CFG_INIT_TO, 16'(it));
    write_reg(CFG_MAX_TO, 16'(mt));
    write_reg(CFG_RETRY_LIM, 16'(rl));
    write_reg(CFG_ROTATE, 16'(ro));
    write_reg(CFG_SRV_CNT, 16'(sc));
  endtask

  function automatic logic [15:0] good_len();
    return 16'($urandom_range(HDR_BYTES, MAXLEN));
  endfunction

  function automatic logic [15:0] any_len();
    if ($urandom_range(9) < 8) return good_len();
    if ($urandom_range(1)) return 16'($urandom_range(HDR_BYTES - 1));
    return 16'($urandom_range(MAXLEN + 1, 65535));
  endfunction

  task automatic rand_item();
    int pick;
    logic [1:0] op;
    logic [15:0] id, len;
    logic qr, tc;
    logic [3:0] rc, cs;
    pick = $urandom_range(99);
    id = 16'($urandom);
    len = any_len();
    qr = ($urandom_range(9) != 0);
    tc = ($urandom_range(4) == 0);
    rc = 4'($urandom);
    cs = 4'($urandom);
    if (pick < 35) op = OP_ISSUE;
    else if (pick < 60) begin
      op = OP_RESP;
      if ($urandom_range(9) < 7) id = sb.live_id();
    end else if (pick < 90) op = OP_TICK;
    else op = OP_CANCEL;
    send_item(op, id, len, qr, tc, rc, cs);
  endtask

  task automatic run_phase(int n, int pct);
    idle_pct = pct;
    repeat (n) rand_item();
    wait_idle();
  endtask

  initial begin
    logic [15:0] ids[DEPTH];
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no servers yet, then both length bounds
    send_item(OP_ISSUE, 16'h1234, 16'd100, 0, 0, 0, 0);
    send_item(OP_ISSUE, 16'hffff, 16'(HDR_BYTES - 1), 1, 1, 4'hf, 4'hf);
    send_item(OP_ISSUE, 16'h0000, 16'(MAXLEN + 1), 0, 0, 0, 0);
    wait_idle();
    // zero timeouts are dropped; a count above the limit clamps
    write_reg(CFG_INIT_TO, 0);
    write_reg(CFG_MAX_TO, 0);
    write_reg(CFG_INIT_TO, 16'hffff);
    write_reg(CFG_SRV_CNT, 9);
    for (int i = 0; i < DEPTH; i++) begin
      ids[i] = 16'($urandom);
      send_item(OP_ISSUE, ids[i], (i == 0) ? 16'(HDR_BYTES) : 16'(MAXLEN), 1, 0, 0, 0);
    end
    send_item(OP_ISSUE, 16'habcd, 16'd64, 1, 0, 0, 0);
    send_item(OP_CANCEL, 0, 0, 0, 0, 0, 4'd3);
    send_item(OP_CANCEL, 0, 0, 0, 0, 0, 4'd3);
    send_item(OP_RESP, ids[0], 16'd40, 1, 1, 0, 0);
    send_item(OP_RESP, ids[1], 16'd40, 1, 0, 4'd5, 0);
    send_item(OP_RESP, ids[2], 16'd40, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 0, 0);
    send_item(OP_CANCEL, 0, 0, 0, 0, 0, 4'd0);
    wait_idle();
    for (int i = 0; i < DEPTH; i++)
      if (sb.live[i]) send_item(OP_CANCEL, 0, 0, 0, 0, 0, 4'(i));
    send_item(OP_TICK, 0, 0, 0, 0, 0, 0);
    wait_idle();

    setup(1, 3, 2, 1, 3);
    run_phase(70, 0);
    setup(2, 16'hffff, 15, 0, 8);
    run_phase(70, 72);
    // live entries now retry with no servers
    setup(1, 2, 15, 1, 0);
    run_phase(30, 0);
    setup(3, 1, 0, 1, 15);
    run_phase(80, 38);

    if (sb.errors == 0 && sb.due_words.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
